FILE: hw/rtl/dtc_pkg.sv
package dtc_pkg;

    // Register file geometry
    localparam int NUM_REGS = 14;
    localparam int NUM_TMR  = 3;
    localparam int PRESC_W  = 5;

    // Timer slots for the per-timer divider and pin history
    localparam int TMR0 = 0;
    localparam int TMR1 = 1;
    localparam int TMR2 = 2;

    // Bus addresses of the special function registers
    localparam logic [7:0] ADDR_TCON  = 8'h88;
    localparam logic [7:0] ADDR_TMOD  = 8'h89;
    localparam logic [7:0] ADDR_TL0   = 8'h8A;
    localparam logic [7:0] ADDR_TL1   = 8'h8B;
    localparam logic [7:0] ADDR_TH0   = 8'h8C;
    localparam logic [7:0] ADDR_TH1   = 8'h8D;
    localparam logic [7:0] ADDR_CKCON = 8'h8E;
    localparam logic [7:0] ADDR_T2CON = 8'hC8;
    localparam logic [7:0] ADDR_T2IF  = 8'hC9;
    localparam logic [7:0] ADDR_RLDL  = 8'hCA;
    localparam logic [7:0] ADDR_RLDH  = 8'hCB;
    localparam logic [7:0] ADDR_TL2   = 8'hCC;
    localparam logic [7:0] ADDR_TH2   = 8'hCD;
    localparam logic [7:0] ADDR_T2IE  = 8'hCF;

    // Bit positions inside the control registers
    localparam int RUN0_POS  = 4;
    localparam int OVF0_POS  = 5;
    localparam int RUN1_POS  = 6;
    localparam int OVF1_POS  = 7;
    localparam int TMOD_CT0  = 2;
    localparam int TMOD_CT1  = 6;
    localparam int FAST0_POS = 3;
    localparam int FAST1_POS = 4;
    localparam int T2CON_DIV = 7;
    localparam int T2IF_FLAG = 7;
    localparam int T2IE_EN   = 7;

    // Prescaler division ratios
    localparam logic [PRESC_W-1:0] DIV_FAST   = 5'd4;
    localparam logic [PRESC_W-1:0] DIV_STD    = 5'd12;
    localparam logic [PRESC_W-1:0] DIV_DOUBLE = 5'd24;

    // Register file slots
    typedef enum logic [3:0] {
        REG_TCON  = 4'd0,
        REG_TMOD  = 4'd1,
        REG_TL0   = 4'd2,
        REG_TH0   = 4'd3,
        REG_TL1   = 4'd4,
        REG_TH1   = 4'd5,
        REG_CKCON = 4'd6,
        REG_T2CON = 4'd7,
        REG_T2IF  = 4'd8,
        REG_RLDL  = 4'd9,
        REG_RLDH  = 4'd10,
        REG_TL2   = 4'd11,
        REG_TH2   = 4'd12,
        REG_T2IE  = 4'd13
    } t_reg_idx;

    // Kind of input item
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_IDLE  = 2'd3
    } t_action;

    // Timer 0/1 operating modes
    typedef enum logic [1:0] {
        MODE_13BIT   = 2'd0,
        MODE_16BIT   = 2'd1,
        MODE_RELOAD8 = 2'd2,
        MODE_HOLD    = 2'd3
    } t_tmr_mode;

    // Timer 2 run modes
    typedef enum logic [1:0] {
        T2_STOP  = 2'd0,
        T2_TIMER = 2'd1,
        T2_PIN   = 2'd2,
        T2_HOLD  = 2'd3
    } t_t2_run;

    // Input item as it travels on the input channel
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       pin_t0;
        logic       pin_t1;
        logic       pin_t2;
    } t_in_item;

    // Result item as it travels on the output channel
    typedef struct packed {
        logic [7:0] read_data;
        logic       flag_t0;
        logic       flag_t1;
        logic       flag_t2;
        logic       irq_t0;
        logic       irq_t1;
        logic       irq_t2;
    } t_out_item;

    // Count, divider and pin history of one timer
    typedef struct packed {
        logic [7:0]         th;
        logic [7:0]         tl;
        logic [PRESC_W-1:0] presc;
        logic               level;
        logic               known;
    } t_tmr_state;

    // Control bits for timer 0 or 1
    typedef struct packed {
        logic      run;
        logic      ext;
        logic      fast;
        t_tmr_mode mode;
    } t_t01_ctrl;

    // Control bits and reload value for timer 2
    typedef struct packed {
        t_t2_run    run;
        logic       slow;
        logic       reload;
        logic [7:0] rldl;
        logic [7:0] rldh;
    } t_t2_ctrl;

    // Result of an address decode
    typedef struct packed {
        logic     hit;
        t_reg_idx idx;
    } t_reg_sel;

    function automatic t_reg_sel reg_decode(input logic [7:0] addr);
        t_reg_sel sel;
        sel.hit = 1'b1;
        sel.idx = REG_TCON;
        case (addr)
            ADDR_TCON:  sel.idx = REG_TCON;
            ADDR_TMOD:  sel.idx = REG_TMOD;
            ADDR_TL0:   sel.idx = REG_TL0;
            ADDR_TL1:   sel.idx = REG_TL1;
            ADDR_TH0:   sel.idx = REG_TH0;
            ADDR_TH1:   sel.idx = REG_TH1;
            ADDR_CKCON: sel.idx = REG_CKCON;
            ADDR_T2CON: sel.idx = REG_T2CON;
            ADDR_T2IF:  sel.idx = REG_T2IF;
            ADDR_RLDL:  sel.idx = REG_RLDL;
            ADDR_RLDH:  sel.idx = REG_RLDH;
            ADDR_TL2:   sel.idx = REG_TL2;
            ADDR_TH2:   sel.idx = REG_TH2;
            ADDR_T2IE:  sel.idx = REG_T2IE;
            default:    sel.hit = 1'b0;
        endcase
        return sel;
    endfunction

endpackage

FILE: hw/rtl/dtc_t01.sv
module dtc_t01
    import dtc_pkg::*;
(
    input  t_t01_ctrl  i_ctrl,
    input  t_tmr_state i_state,
    input  logic       i_pin,
    output t_tmr_state o_state,
    output logic       o_ovf
);

    logic [PRESC_W-1:0] presc_inc;
    logic [PRESC_W-1:0] div;
    logic               fall;
    logic               bump;
    logic [12:0]        cnt13;
    logic [15:0]        cnt16;
    logic [7:0]         cnt8;

    // Increment candidates for each counting width, the divider ratio and the pin fall
    assign presc_inc = i_state.presc + 5'd1;
    assign div       = i_ctrl.fast ? DIV_FAST : DIV_STD;
    assign fall      = i_state.known && i_state.level && !i_pin;
    assign cnt13     = {i_state.th[4:0], i_state.tl} + 13'd1;
    assign cnt16     = {i_state.th, i_state.tl} + 16'd1;
    assign cnt8      = i_state.tl + 8'd1;

    // One tick: decide whether the count advances, then advance it.
    always_comb begin
        o_state = i_state;
        o_ovf   = 1'b0;
        bump    = 1'b0;
        if (i_ctrl.run) begin
            if (i_ctrl.ext) begin
                o_state.level = i_pin;
                o_state.known = 1'b1;
                bump          = fall;
            end else if (i_ctrl.mode != MODE_HOLD) begin
                if (presc_inc >= div) begin
                    o_state.presc = '0;
                    bump          = 1'b1;
                end else begin
                    o_state.presc = presc_inc;
                end
            end
        end
        if (bump) begin
            case (i_ctrl.mode)
                MODE_13BIT: begin
                    o_state.th = {i_state.th[7:5], cnt13[12:8]};
                    o_state.tl = cnt13[7:0];
                    o_ovf      = (cnt13 == 13'd0);
                end
                MODE_16BIT: begin
                    o_state.th = cnt16[15:8];
                    o_state.tl = cnt16[7:0];
                    o_ovf      = (cnt16 == 16'd0);
                end
                MODE_RELOAD8: begin
                    if (cnt8 == 8'd0) begin
                        o_state.tl = i_state.th;
                        o_ovf      = 1'b1;
                    end else begin
                        o_state.tl = cnt8;
                    end
                end
                default: begin
                    o_ovf = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/dtc_t2.sv
module dtc_t2
    import dtc_pkg::*;
(
    input  t_t2_ctrl   i_ctrl,
    input  t_tmr_state i_state,
    input  logic       i_pin,
    output t_tmr_state o_state,
    output logic       o_ovf
);

    logic [PRESC_W-1:0] presc_inc;
    logic [PRESC_W-1:0] div;
    logic               fall;
    logic               bump;
    logic [15:0]        cnt16;

    assign presc_inc = i_state.presc + 5'd1;
    assign div       = i_ctrl.slow ? DIV_DOUBLE : DIV_STD;
    assign fall      = i_state.known && i_state.level && !i_pin;
    assign cnt16     = {i_state.th, i_state.tl} + 16'd1;

    // One tick of timer 2; a wrap reloads from RLD or clears to zero.
    always_comb begin
        o_state = i_state;
        o_ovf   = 1'b0;
        bump    = 1'b0;
        case (i_ctrl.run)
            T2_PIN: begin
                o_state.level = i_pin;
                o_state.known = 1'b1;
                bump          = fall;
            end
            T2_TIMER: begin
                if (presc_inc >= div) begin
                    o_state.presc = '0;
                    bump          = 1'b1;
                end else begin
                    o_state.presc = presc_inc;
                end
            end
            default: begin
                bump = 1'b0;
            end
        endcase
        if (bump) begin
            if (cnt16 != 16'd0) begin
                o_state.th = cnt16[15:8];
                o_state.tl = cnt16[7:0];
            end else begin
                o_ovf = 1'b1;
                if (i_ctrl.reload) begin
                    o_state.th = i_ctrl.rldh;
                    o_state.tl = i_ctrl.rldl;
                end else begin
                    o_state.th = 8'd0;
                    o_state.tl = 8'd0;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/dual_timer_counter_with_reload.sv
// Timer peripheral with two classic 8051 timers and a reload timer 2.
// Input channel (i_in_valid, i_in_data, o_in_stall) carries one item per
// transfer: a clock tick with the three pin samples, a register write, a
// register read or an idle item. Output channel (o_out_valid, o_out_data,
// i_out_stall) returns exactly one result per item: read data, the three
// overflow flags and the three overflow pulses.
// An item taken from the input channel sits in the input register; its
// result is then captured in the output register, which drives
// o_out_valid. Throughput is one item per cycle while the receiver does not
// stall: the input register feeds a single pass of update logic into the
// output register, and the register file is updated at the same edge as the
// result is captured.
// While the receiver stalls, the result is held and one more item waits in
// the input register; o_in_stall rises when both are occupied and the
// receiver stalls.
// A synchronous reset (i_rst_n low) clears all timer registers, dividers
// and pin history, and empties both pipeline registers.
module dual_timer_counter_with_reload
    import dtc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [7:0]         r_sfr   [NUM_REGS];
    logic [7:0]         n_sfr   [NUM_REGS];
    logic [PRESC_W-1:0] r_presc [NUM_TMR];
    logic [PRESC_W-1:0] n_presc [NUM_TMR];
    logic [NUM_TMR-1:0] r_level;
    logic [NUM_TMR-1:0] n_level;
    logic [NUM_TMR-1:0] r_known;
    logic [NUM_TMR-1:0] n_known;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;
    logic       advance;
    t_reg_sel   sel;

    t_t01_ctrl  ctrl0;
    t_t01_ctrl  ctrl1;
    t_t2_ctrl   ctrl2;
    t_tmr_state cur0;
    t_tmr_state cur1;
    t_tmr_state cur2;
    t_tmr_state nxt0;
    t_tmr_state nxt1;
    t_tmr_state nxt2;
    logic       ovf0;
    logic       ovf1;
    logic       ovf2;

    // The waiting item moves on whenever the output register is free or drained.
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Input register: takes a new transfer whenever it is not held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_item  <= '0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
            if (i_in_valid) begin
                r_in_item <= i_in_data;
            end
        end
    end

    // Output register: loads a result or empties once it has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_item  <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_out_item  <= n_out_item;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Timer state changes only when an item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfr   <= '{default: '0};
            r_presc <= '{default: '0};
            r_level <= '0;
            r_known <= '0;
        end else if (advance) begin
            r_sfr   <= n_sfr;
            r_presc <= n_presc;
            r_level <= n_level;
            r_known <= n_known;
        end
    end

    // Control and current state presented to the three timer slices.
    always_comb begin
        ctrl0.run    = r_sfr[REG_TCON][RUN0_POS];
        ctrl0.ext    = r_sfr[REG_TMOD][TMOD_CT0];
        ctrl0.fast   = r_sfr[REG_CKCON][FAST0_POS];
        ctrl0.mode   = t_tmr_mode'(r_sfr[REG_TMOD][1:0]);
        ctrl1.run    = r_sfr[REG_TCON][RUN1_POS];
        ctrl1.ext    = r_sfr[REG_TMOD][TMOD_CT1];
        ctrl1.fast   = r_sfr[REG_CKCON][FAST1_POS];
        ctrl1.mode   = t_tmr_mode'(r_sfr[REG_TMOD][5:4]);
        ctrl2.run    = t_t2_run'(r_sfr[REG_T2CON][1:0]);
        ctrl2.slow   = r_sfr[REG_T2CON][T2CON_DIV];
        ctrl2.reload = |r_sfr[REG_T2CON][5:4];
        ctrl2.rldl   = r_sfr[REG_RLDL];
        ctrl2.rldh   = r_sfr[REG_RLDH];

        cur0.th    = r_sfr[REG_TH0];
        cur0.tl    = r_sfr[REG_TL0];
        cur0.presc = r_presc[TMR0];
        cur0.level = r_level[TMR0];
        cur0.known = r_known[TMR0];
        cur1.th    = r_sfr[REG_TH1];
        cur1.tl    = r_sfr[REG_TL1];
        cur1.presc = r_presc[TMR1];
        cur1.level = r_level[TMR1];
        cur1.known = r_known[TMR1];
        cur2.th    = r_sfr[REG_TH2];
        cur2.tl    = r_sfr[REG_TL2];
        cur2.presc = r_presc[TMR2];
        cur2.level = r_level[TMR2];
        cur2.known = r_known[TMR2];
    end

    dtc_t01 u_t0 (
        .i_ctrl  (ctrl0),
        .i_state (cur0),
        .i_pin   (r_in_item.pin_t0),
        .o_state (nxt0),
        .o_ovf   (ovf0)
    );

    dtc_t01 u_t1 (
        .i_ctrl  (ctrl1),
        .i_state (cur1),
        .i_pin   (r_in_item.pin_t1),
        .o_state (nxt1),
        .o_ovf   (ovf1)
    );

    dtc_t2 u_t2 (
        .i_ctrl  (ctrl2),
        .i_state (cur2),
        .i_pin   (r_in_item.pin_t2),
        .o_state (nxt2),
        .o_ovf   (ovf2)
    );

    assign sel = reg_decode(r_in_item.reg_addr);

    // Next register file and result for the item in the input register.
    always_comb begin
        n_sfr      = r_sfr;
        n_presc    = r_presc;
        n_level    = r_level;
        n_known    = r_known;
        n_out_item = '0;
        case (r_in_item.action)
            ACT_TICK: begin
                n_sfr[REG_TH0] = nxt0.th;
                n_sfr[REG_TL0] = nxt0.tl;
                n_presc[TMR0]  = nxt0.presc;
                n_level[TMR0]  = nxt0.level;
                n_known[TMR0]  = nxt0.known;
                n_sfr[REG_TH1] = nxt1.th;
                n_sfr[REG_TL1] = nxt1.tl;
                n_presc[TMR1]  = nxt1.presc;
                n_level[TMR1]  = nxt1.level;
                n_known[TMR1]  = nxt1.known;
                n_sfr[REG_TH2] = nxt2.th;
                n_sfr[REG_TL2] = nxt2.tl;
                n_presc[TMR2]  = nxt2.presc;
                n_level[TMR2]  = nxt2.level;
                n_known[TMR2]  = nxt2.known;
                n_sfr[REG_TCON][OVF0_POS]  = r_sfr[REG_TCON][OVF0_POS] | ovf0;
                n_sfr[REG_TCON][OVF1_POS]  = r_sfr[REG_TCON][OVF1_POS] | ovf1;
                n_sfr[REG_T2IF][T2IF_FLAG] = r_sfr[REG_T2IF][T2IF_FLAG] | ovf2;
                n_out_item.irq_t0 = ovf0;
                n_out_item.irq_t1 = ovf1;
                n_out_item.irq_t2 = ovf2 & r_sfr[REG_T2IE][T2IE_EN];
            end
            ACT_WRITE: begin
                if (sel.hit) begin
                    n_sfr[sel.idx] = r_in_item.write_data;
                    // Writes that restart a divider's phase.
                    case (sel.idx)
                        REG_TCON: begin
                            if (r_sfr[REG_TCON][RUN0_POS] != r_in_item.write_data[RUN0_POS]) begin
                                n_presc[TMR0] = '0;
                            end
                            if (r_sfr[REG_TCON][RUN1_POS] != r_in_item.write_data[RUN1_POS]) begin
                                n_presc[TMR1] = '0;
                            end
                        end
                        REG_TMOD, REG_CKCON: begin
                            n_presc[TMR0] = '0;
                            n_presc[TMR1] = '0;
                        end
                        REG_TL0, REG_TH0: begin
                            n_presc[TMR0] = '0;
                        end
                        REG_TL1, REG_TH1: begin
                            n_presc[TMR1] = '0;
                        end
                        REG_T2CON: begin
                            if (r_sfr[REG_T2CON][1:0] != r_in_item.write_data[1:0]) begin
                                n_presc[TMR2] = '0;
                            end
                        end
                        REG_TL2, REG_TH2, REG_RLDL, REG_RLDH: begin
                            n_presc[TMR2] = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ACT_READ: begin
                if (sel.hit) begin
                    n_out_item.read_data = r_sfr[sel.idx];
                end
            end
            default: begin
            end
        endcase
        n_out_item.flag_t0 = n_sfr[REG_TCON][OVF0_POS];
        n_out_item.flag_t1 = n_sfr[REG_TCON][OVF1_POS];
        n_out_item.flag_t2 = n_sfr[REG_T2IF][T2IF_FLAG];
    end

endmodule

FILE: hw/rtl/dtc_chk.sv
module dtc_chk
    import dtc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A held result stays put while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // The input side only backs up when the output side is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // Every input transfer is later followed by a valid output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("result missing after input transfer");

    // An overflow pulse always comes with its flag set.
    a_irq_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.irq_t0 || o_out_data.flag_t0)
                     && (!o_out_data.irq_t1 || o_out_data.flag_t1)
                     && (!o_out_data.irq_t2 || o_out_data.flag_t2))
        else $error("overflow pulse without flag");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind dual_timer_counter_with_reload dtc_chk u_dtc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
